>>> sv/lpr_pkg.sv
// -----------------------------------------------------------------------------
// lpr_pkg
// Shared types and constants for the line pixel rasterizer: the request and
// response payloads and the segment descriptor passed from front to back.
// -----------------------------------------------------------------------------
package lpr_pkg;

   // Width of every coordinate field on the ports
   localparam int COORD_W = 6;
   // Default number of coordinate bits actually used
   localparam int COORD_BITS_DEF = 6;
   // Width of the colour field
   localparam int COLOUR_W = 32;
   // Entries in the descriptor queue (power of two)
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [COORD_W-1:0]  start_x;
      logic [COORD_W-1:0]  start_y;
      logic [COORD_W-1:0]  end_x;
      logic [COORD_W-1:0]  end_y;
      logic [COLOUR_W-1:0] pixel_colour;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0]  pixel_x;
      logic [COORD_W-1:0]  pixel_y;
      logic [COLOUR_W-1:0] colour_out;
      logic                last_pixel;
   } rsp_type;

   // Classified segment: start point, deltas along the major and minor axes,
   // axis choice and step directions.
   typedef struct packed {
      logic [COORD_W-1:0]  x0;
      logic [COORD_W-1:0]  y0;
      logic [COORD_W-1:0]  major;
      logic [COORD_W-1:0]  minor;
      logic                x_major;
      logic                major_neg;
      logic                minor_neg;
      logic [COLOUR_W-1:0] colour;
   } desc_type;

endpackage

>>> sv/lpr_front.sv
// -----------------------------------------------------------------------------
// lpr_front
// Accepts segments and classifies them: absolute deltas, major axis and step
// directions, pushed as one descriptor into the queue.
// -----------------------------------------------------------------------------
module lpr_front #(
   parameter int COORD_BITS = lpr_pkg::COORD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lpr_pkg::req_type  req_data,
   input  logic              q_full,
   output logic              q_push,
   output lpr_pkg::desc_type q_desc
);

   logic [COORD_BITS-1:0] xs, ys, xe, ye;
   logic [COORD_BITS-1:0] adx, ady;
   logic                  x_neg, y_neg, x_major;

   // Keep only the low coordinate bits
   assign xs = req_data.start_x[COORD_BITS-1:0];
   assign ys = req_data.start_y[COORD_BITS-1:0];
   assign xe = req_data.end_x[COORD_BITS-1:0];
   assign ye = req_data.end_y[COORD_BITS-1:0];

   assign x_neg = (xe < xs);
   assign y_neg = (ye < ys);
   assign adx   = x_neg ? (xs - xe) : (xe - xs);
   assign ady   = y_neg ? (ys - ye) : (ye - ys);
   // Equal deltas walk along y
   assign x_major = (ady < adx);

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_desc           = '0;
      q_desc.x0        = lpr_pkg::COORD_W'(xs);
      q_desc.y0        = lpr_pkg::COORD_W'(ys);
      q_desc.major     = lpr_pkg::COORD_W'(x_major ? adx : ady);
      q_desc.minor     = lpr_pkg::COORD_W'(x_major ? ady : adx);
      q_desc.x_major   = x_major;
      q_desc.major_neg = x_major ? x_neg : y_neg;
      q_desc.minor_neg = x_major ? y_neg : x_neg;
      q_desc.colour    = req_data.pixel_colour;
   end

   // A stalled segment must not enter the queue
   a_no_push_on_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> !q_push)
      else $error("push while stalled");

endmodule

>>> sv/lpr_queue.sv
// -----------------------------------------------------------------------------
// lpr_queue
// Short descriptor queue between the front and the walker.
// -----------------------------------------------------------------------------
module lpr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lpr_pkg::desc_type push_desc,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output lpr_pkg::desc_type pop_desc
);

   localparam int PTR_W = (lpr_pkg::QUEUE_DEPTH > 1) ? $clog2(lpr_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(lpr_pkg::QUEUE_DEPTH + 1);

   lpr_pkg::desc_type mem_ff [lpr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full     = (count_ff == CNT_W'(lpr_pkg::QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_desc = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(lpr_pkg::QUEUE_DEPTH))
      else $error("queue count over depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid)
      else $error("pop from empty queue");

endmodule

>>> sv/lpr_walk.sv
// -----------------------------------------------------------------------------
// lpr_walk
// Bresenham walker: loads one descriptor, then, unless stalled, steps one pixel
// per cycle into the response register until the end pixel has been sent.
// -----------------------------------------------------------------------------
module lpr_walk #(
   parameter int COORD_BITS = lpr_pkg::COORD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  lpr_pkg::desc_type q_desc,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lpr_pkg::rsp_type  rsp_data
);

   logic                         busy_ff, busy_in;
   logic [COORD_BITS-1:0]        x_ff, x_in, y_ff, y_in;
   logic [COORD_BITS:0]          acc_ff, acc_in;
   logic [COORD_BITS-1:0]        left_ff, left_in;
   logic [COORD_BITS-1:0]        major_ff, minor_ff;
   logic                         x_major_ff, major_neg_ff, minor_neg_ff;
   logic [lpr_pkg::COLOUR_W-1:0] colour_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   lpr_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic                         can_emit, emit, last;
   logic [COORD_BITS:0]          acc_sum;
   logic                         minor_step, x_step, y_step, x_neg, y_neg;

   assign can_emit = !rsp_valid_ff || !rsp_stall;
   assign emit     = busy_ff && can_emit;
   assign last     = (left_ff == '0);
   assign q_pop    = !busy_ff && q_valid;

   assign acc_sum    = acc_ff + (COORD_BITS+1)'(minor_ff);
   assign minor_step = (acc_sum > {1'b0, major_ff});
   assign x_step     = x_major_ff || minor_step;
   assign y_step     = !x_major_ff || minor_step;
   assign x_neg      = x_major_ff ? major_neg_ff : minor_neg_ff;
   assign y_neg      = x_major_ff ? minor_neg_ff : major_neg_ff;

   always_comb begin
      busy_in      = busy_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      acc_in       = acc_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (can_emit) begin
         rsp_valid_in = busy_ff;
      end
      if (emit) begin
         rsp_data_in.pixel_x    = lpr_pkg::COORD_W'(x_ff);
         rsp_data_in.pixel_y    = lpr_pkg::COORD_W'(y_ff);
         rsp_data_in.colour_out = colour_ff;
         rsp_data_in.last_pixel = last;
         if (last) begin
            busy_in = 1'b0;
         end else begin
            // Advance along the major axis, step the minor axis on overflow
            acc_in  = minor_step ? (acc_sum - {1'b0, major_ff}) : acc_sum;
            left_in = left_ff - 1'b1;
            if (x_step) begin
               x_in = x_neg ? (x_ff - 1'b1) : (x_ff + 1'b1);
            end
            if (y_step) begin
               y_in = y_neg ? (y_ff - 1'b1) : (y_ff + 1'b1);
            end
         end
      end
      if (q_pop) begin
         busy_in = 1'b1;
         x_in    = q_desc.x0[COORD_BITS-1:0];
         y_in    = q_desc.y0[COORD_BITS-1:0];
         acc_in  = (COORD_BITS+1)'(q_desc.major[COORD_BITS-1:1]);
         left_in = q_desc.major[COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      acc_ff      <= acc_in;
      left_ff     <= left_in;
      rsp_data_ff <= rsp_data_in;
      if (q_pop) begin
         major_ff     <= q_desc.major[COORD_BITS-1:0];
         minor_ff     <= q_desc.minor[COORD_BITS-1:0];
         x_major_ff   <= q_desc.x_major;
         major_neg_ff <= q_desc.major_neg;
         minor_neg_ff <= q_desc.minor_neg;
         colour_ff    <= q_desc.colour;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (acc_ff <= {1'b0, major_ff}))
      else $error("error accumulator above major delta");

   a_last_ends_walk: assert property (@(posedge clock) disable iff (reset)
      (emit && last) |=> (!busy_ff && rsp_valid_ff && rsp_data_ff.last_pixel))
      else $error("walk did not end on the end pixel");

endmodule

>>> sv/line_pixel_rasterizer.sv
// -----------------------------------------------------------------------------
// line_pixel_rasterizer
// Bresenham line walker: one segment in, its pixels out from start to end.
// -----------------------------------------------------------------------------
// A transferred segment passes the descriptor queue, the walker's load and the
//   response register before its first pixel is valid on rsp.
// Throughput: one pixel per cycle while rsp_stall is low; a segment is one
//   descriptor load, then its pixels, and the next loads once the walker idles.
// Reset clears the descriptor queue, the walker and the response valid.
// -----------------------------------------------------------------------------
module line_pixel_rasterizer #(
   parameter int COORD_BITS = lpr_pkg::COORD_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // segment channel
   input  logic             req_valid,
   output logic             req_stall,
   input  lpr_pkg::req_type req_data,
   // pixel channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lpr_pkg::rsp_type rsp_data
);

   // Front to queue
   logic              q_push;
   logic              q_full;
   lpr_pkg::desc_type push_desc;
   // Queue to walker
   logic              q_pop;
   logic              q_valid;
   lpr_pkg::desc_type pop_desc;

   // Classify each segment as it is transferred; stall only when the queue
   // is full, so a new segment can be taken while the walker is drawing.
   lpr_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_desc    (push_desc)
   );

   // Hold classified segments until the walker is free
   lpr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_desc  (pop_desc)
   );

   // Walk one segment, one pixel per response transfer; the response register
   // frees the walker from the consumer for one pixel.
   lpr_walk #(
      .COORD_BITS (COORD_BITS)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_desc    (pop_desc),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> test/tb_line_pixel_rasterizer.sv
// -----------------------------------------------------------------------------
// tb_line_pixel_rasterizer
// Self-checking bench for the Bresenham line walker. Each segment transfer is
// run through an in-bench line walk that queues the pixels it should produce;
// every pixel transfer on the response side is checked field by field against
// the oldest queued pixel. Directed segments cover points, straight lines,
// diagonals and accumulator ties; random segments then run under sender and
// receiver idling, a long receiver hold-off and a sender pause.
// -----------------------------------------------------------------------------
module tb_line_pixel_rasterizer;

   localparam int COORD_MAX     = (1 << lpr_pkg::COORD_BITS_DEF) - 1;
   // Worst run is about 470 segments of 64 pixels at a 61% receiver stall;
   // the limit leaves ample margin.
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int HOLD_CYCLES   = 300;
   // Margin run after the final drain, so a stray extra pixel is caught.
   localparam int SETTLE_CYCLES = 8;

   typedef enum int {
      SHAPE_ANY,
      SHAPE_SHORT,
      SHAPE_STRAIGHT,
      SHAPE_DIAGONAL,
      SHAPE_NEAR_DIAG,
      SHAPE_POINT
   } shape_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   lpr_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   lpr_pkg::rsp_type rsp_data;

   // Pixels still owed by the block, oldest first
   lpr_pkg::rsp_type pending_pixels[$];
   int               mismatch_count = 0;
   int               cycle_count    = 0;
   // Idle chances in percent per cycle for each side
   int               send_idle_pct  = 0;
   int               recv_idle_pct  = 0;
   // Hold-off request from the test sequence and its running count
   int               hold_ask       = 0;
   int               hold_left      = 0;

   line_pixel_rasterizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #6 clock = ~clock;

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("line_pixel_rasterizer test failed");
         $finish;
      end
   end

   // Walk one segment and queue every pixel it covers, start to end.
   // The accumulator starts at half the major delta; the minor axis steps
   // only when it strictly exceeds the major delta. Ties go y-major.
   task automatic predict_pixels(input lpr_pkg::req_type seg);
      int               mask, x, y, xe, ye, sx, sy, adx, ady, err;
      lpr_pkg::rsp_type px;
      mask = (1 << lpr_pkg::COORD_BITS_DEF) - 1;
      x    = int'(seg.start_x) & mask;
      y    = int'(seg.start_y) & mask;
      xe   = int'(seg.end_x) & mask;
      ye   = int'(seg.end_y) & mask;
      sx   = (xe > x) ? 1 : ((xe < x) ? -1 : 0);
      sy   = (ye > y) ? 1 : ((ye < y) ? -1 : 0);
      adx  = (xe > x) ? xe - x : x - xe;
      ady  = (ye > y) ? ye - y : y - ye;
      px.colour_out = seg.pixel_colour;
      px.last_pixel = 1'b0;
      if (ady < adx) begin
         err = adx / 2;
         while (x != xe) begin
            px.pixel_x = x[lpr_pkg::COORD_W-1:0];
            px.pixel_y = y[lpr_pkg::COORD_W-1:0];
            pending_pixels.push_back(px);
            err += ady;
            if (err > adx) begin
               err -= adx;
               y += sy;
            end
            x += sx;
         end
      end else begin
         err = ady / 2;
         while (y != ye) begin
            px.pixel_x = x[lpr_pkg::COORD_W-1:0];
            px.pixel_y = y[lpr_pkg::COORD_W-1:0];
            pending_pixels.push_back(px);
            err += adx;
            if (err > ady) begin
               err -= ady;
               x += sx;
            end
            y += sy;
         end
      end
      // The end pixel appears once, marked last; a point yields only this.
      px.pixel_x    = x[lpr_pkg::COORD_W-1:0];
      px.pixel_y    = y[lpr_pkg::COORD_W-1:0];
      px.last_pixel = 1'b1;
      pending_pixels.push_back(px);
   endtask

   // Check each pixel transfer against the oldest owed pixel.
   always @(posedge clock) begin : check_pixels
      lpr_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel: x %0d y %0d colour %h last %0b",
                   rsp_data.pixel_x, rsp_data.pixel_y, rsp_data.colour_out,
                   rsp_data.last_pixel);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.pixel_x !== want.pixel_x) begin
               $error("pixel_x: expected %0d, actual %0d", want.pixel_x, rsp_data.pixel_x);
               mismatch_count++;
            end
            if (rsp_data.pixel_y !== want.pixel_y) begin
               $error("pixel_y: expected %0d, actual %0d", want.pixel_y, rsp_data.pixel_y);
               mismatch_count++;
            end
            if (rsp_data.colour_out !== want.colour_out) begin
               $error("colour_out: expected %h, actual %h",
                      want.colour_out, rsp_data.colour_out);
               mismatch_count++;
            end
            if (rsp_data.last_pixel !== want.last_pixel) begin
               $error("last_pixel: expected %0b, actual %0b",
                      want.last_pixel, rsp_data.last_pixel);
               mismatch_count++;
            end
         end
      end
   end

   // Drive the pixel-side stall: a requested hold-off wins, else random idling.
   always @(posedge clock) begin
      if (hold_ask != 0) begin
         hold_left = hold_ask;
         hold_ask  = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Offer one segment, after a random gap, and hold it until the transfer.
   task automatic send_segment(input lpr_pkg::req_type seg);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= seg;
      do @(posedge clock); while (req_stall);
      predict_pixels(seg);
   endtask

   task automatic send_line(input int x0, y0, x1, y1,
                            input logic [lpr_pkg::COLOUR_W-1:0] colour);
      lpr_pkg::req_type seg;
      seg.start_x      = x0[lpr_pkg::COORD_W-1:0];
      seg.start_y      = y0[lpr_pkg::COORD_W-1:0];
      seg.end_x        = x1[lpr_pkg::COORD_W-1:0];
      seg.end_y        = y1[lpr_pkg::COORD_W-1:0];
      seg.pixel_colour = colour;
      send_segment(seg);
   endtask

   // Drop valid and hold until every owed pixel has arrived.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
   endtask

   function automatic int clamp_coord(input int v);
      return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
   endfunction

   // Draw a segment, weighted toward shapes with corner cases in the walk.
   function automatic lpr_pkg::req_type random_segment();
      lpr_pkg::req_type seg;
      shape_type        shape;
      int               roll, x0, y0, x1, y1, ux, uy, room, d;
      roll = $urandom_range(99);
      if (roll < 35)
         shape = SHAPE_ANY;
      else if (roll < 60)
         shape = SHAPE_SHORT;
      else if (roll < 72)
         shape = SHAPE_STRAIGHT;
      else if (roll < 84)
         shape = SHAPE_DIAGONAL;
      else if (roll < 94)
         shape = SHAPE_NEAR_DIAG;
      else
         shape = SHAPE_POINT;
      x0   = $urandom_range(COORD_MAX);
      y0   = $urandom_range(COORD_MAX);
      ux   = $urandom_range(1) ? 1 : -1;
      uy   = $urandom_range(1) ? 1 : -1;
      room = (ux > 0) ? COORD_MAX - x0 : x0;
      if (((uy > 0) ? COORD_MAX - y0 : y0) < room)
         room = (uy > 0) ? COORD_MAX - y0 : y0;
      d    = $urandom_range(room);
      x1   = x0;
      y1   = y0;
      case (shape)
         SHAPE_ANY: begin
            x1 = $urandom_range(COORD_MAX);
            y1 = $urandom_range(COORD_MAX);
         end
         SHAPE_SHORT: begin
            x1 = clamp_coord(x0 + int'($urandom_range(14)) - 7);
            y1 = clamp_coord(y0 + int'($urandom_range(14)) - 7);
         end
         SHAPE_STRAIGHT: begin
            if ($urandom_range(1))
               x1 = $urandom_range(COORD_MAX);
            else
               y1 = $urandom_range(COORD_MAX);
         end
         SHAPE_DIAGONAL: begin
            x1 = x0 + ux * d;
            y1 = y0 + uy * d;
         end
         SHAPE_NEAR_DIAG: begin
            // One axis one step longer: just on either side of the tie
            x1 = x0 + ux * d;
            y1 = y0 + uy * d;
            if ($urandom_range(1))
               x1 = clamp_coord(x1 + ux);
            else
               y1 = clamp_coord(y1 + uy);
         end
         default: ;
      endcase
      seg.start_x      = x0[lpr_pkg::COORD_W-1:0];
      seg.start_y      = y0[lpr_pkg::COORD_W-1:0];
      seg.end_x        = x1[lpr_pkg::COORD_W-1:0];
      seg.end_y        = y1[lpr_pkg::COORD_W-1:0];
      seg.pixel_colour = $urandom();
      return seg;
   endfunction

   // Zero-length segments: one pixel each, marked last.
   task automatic test_points();
      send_line(0, 0, 0, 0, 32'h0000_0000);
      send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
      send_line(21, 42, 21, 42, 32'hA5A5_A5A5);
      wait_for_drain();
   endtask

   // Full-length horizontal and vertical lines in both directions.
   task automatic test_straight_lines();
      send_line(0, 0, COORD_MAX, 0, 32'h5A5A_5A5A);
      send_line(COORD_MAX, COORD_MAX, 0, COORD_MAX, 32'h1234_5678);
      send_line(0, 0, 0, COORD_MAX, 32'h8765_4321);
      send_line(5, COORD_MAX, 5, 0, 32'hFFFF_0000);
      wait_for_drain();
   endtask

   // Equal deltas take the y-major walk; cover all four directions.
   task automatic test_diagonals();
      send_line(0, 0, COORD_MAX, COORD_MAX, 32'h0000_FFFF);
      send_line(COORD_MAX, 0, 0, COORD_MAX, 32'hDEAD_BEEF);
      send_line(COORD_MAX, COORD_MAX, 0, 0, 32'h0F0F_0F0F);
      send_line(0, COORD_MAX, COORD_MAX, 0, 32'hF0F0_F0F0);
      send_line(10, 10, 11, 11, 32'h8000_0001);
      wait_for_drain();
   endtask

   // Accumulator landing exactly on the major delta must not step the
   // minor axis; deltas one apart sit right beside the axis choice.
   task automatic test_accumulator_edges();
      send_line(0, 0, 2, 1, 32'h0000_0001);
      send_line(0, 0, 1, 2, 32'h8000_0000);
      send_line(0, 0, COORD_MAX, COORD_MAX - 1, 32'h3C3C_3C3C);
      send_line(COORD_MAX, 0, 1, COORD_MAX, 32'hC3C3_C3C3);
      send_line(0, 0, COORD_MAX, 1, 32'h7FFF_FFFF);
      send_line(0, COORD_MAX, 1, 0, 32'hFFFF_FFFE);
      send_line(40, 30, 37, 32, 32'h2468_ACE0);
      send_line(20, 20, 13, 26, 32'h1357_9BDF);
      wait_for_drain();
   endtask

   task automatic test_random_stream(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count)
         send_segment(random_segment());
      wait_for_drain();
   endtask

   // Hold the pixel side off while segments keep coming, so the descriptor
   // queue fills and the block stalls its segment side.
   task automatic test_output_hold_off();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_ask      = HOLD_CYCLES;
      repeat (12)
         send_segment(random_segment());
      wait_for_drain();
   endtask

   // Pause the sender until the block has emptied, then resume.
   task automatic test_sender_pause();
      send_idle_pct = 10;
      recv_idle_pct = 10;
      repeat (6)
         send_segment(random_segment());
      wait_for_drain();
      repeat (6)
         send_segment(random_segment());
      wait_for_drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 26;
      recv_idle_pct = 61;
      test_points();
      test_straight_lines();
      test_diagonals();
      test_accumulator_edges();

      test_random_stream(150, 26, 61);
      test_random_stream(150, 61, 26);
      test_output_hold_off();
      test_sender_pause();
      test_random_stream(125, 0, 0);

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("line_pixel_rasterizer test passed");
      else
         $display("line_pixel_rasterizer test failed");
      $finish;
   end

endmodule
